### src/grq_pkg.sv
// ----------------------------------------------------------------------------
// grq_pkg
// Shared types, constants and helpers for the graph reachability query block.
// ----------------------------------------------------------------------------
package grq_pkg;

   localparam int VERTICES = 64;
   localparam int VTX_W    = $clog2(VERTICES);
   localparam int MODE_W   = 2;
   localparam int FIELD_W  = 6;

   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   typedef logic [VERTICES-1:0] row_type;
   typedef logic [VTX_W-1:0]    vtx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_WALK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic rd_en;
      logic rd_from_req;
      logic row_write;
      logic clear_all;
      logic query_init;
      logic absorb;
      logic expand;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic req_ok;
      logic more_pending;
   } status_type;

   function automatic vtx_type pick_first(input row_type mask);
      vtx_type idx;
      idx = '0;
      for (int i = VERTICES - 1; i >= 0; i--) begin
         if (mask[i]) begin
            idx = vtx_type'(i);
         end
      end
      return idx;
   endfunction

endpackage

### src/graph_reachability_query.sv
// ----------------------------------------------------------------------------
// graph_reachability_query
// Directed graph held as an adjacency bit matrix. Items add an edge, clear
// the graph, or ask whether a target is reachable from a source over one or
// more edges; a query walks the graph, lowest-numbered pending vertex first.
//
//   Channel   Ports                                   Direction
//   req       req_valid, req_stall, req_mode,
//             req_from_vertex, req_to_vertex          in (stall out)
//   rsp       rsp_valid, rsp_stall, rsp_reachable     out (stall in)
//
// An edge add reads the source row and writes it back with the new edge set.
// A query reads one adjacency row per cycle from the row memory: the source
// row first, then the row of each vertex expanded.
// Reset clears the per-row valid bits at once, so the graph reads empty
// right away without a clearing pass.
// The result register lets adds and clears proceed while a result waits;
// a finished query holds until the result register is free.
// ----------------------------------------------------------------------------
module graph_reachability_query (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [grq_pkg::MODE_W-1:0]   req_mode,
   input  logic [grq_pkg::FIELD_W-1:0]  req_from_vertex,
   input  logic [grq_pkg::FIELD_W-1:0]  req_to_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_reachable
);
   import grq_pkg::*;

   cmd_type    cmd;
   status_type status;

   grq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   grq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .cmd             (cmd),
      .status          (status),
      .rsp_reachable   (rsp_reachable)
   );

endmodule

### src/grq_ctrl.sv
// ----------------------------------------------------------------------------
// grq_ctrl
// Sequencer for edge adds, graph clears and reachability walks, plus the
// result handshake.
// ----------------------------------------------------------------------------
module grq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_mode,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  grq_pkg::status_type  status,
   output grq_pkg::cmd_type     cmd
);
   import grq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_ADD: begin
                     if (status.req_ok) begin
                        state_in = ST_ADD_WR;
                     end
                  end
                  MODE_QUERY: begin
                     state_in = status.req_ok ? ST_WALK : ST_RESULT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADD_WR: begin
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            if (!status.more_pending) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               case (req_mode)
                  MODE_ADD: begin
                     cmd.rd_en       = status.req_ok;
                     cmd.rd_from_req = 1'b1;
                  end
                  MODE_QUERY: begin
                     cmd.rd_en       = status.req_ok;
                     cmd.rd_from_req = 1'b1;
                     cmd.query_init  = 1'b1;
                  end
                  MODE_CLEAR: begin
                     cmd.clear_all = 1'b1;
                  end
                  default: begin
                     cmd.load_item = 1'b1;
                  end
               endcase
            end
         end
         ST_ADD_WR: begin
            cmd.row_write = 1'b1;
         end
         ST_WALK: begin
            cmd.absorb = 1'b1;
            cmd.expand = status.more_pending;
            cmd.rd_en  = status.more_pending;
         end
         ST_RESULT: begin
            cmd.load_result = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/grq_datapath.sv
// ----------------------------------------------------------------------------
// grq_datapath
// Adjacency row memory with per-row valid bits, visited and pending masks,
// next-vertex selection and the result register.
// ----------------------------------------------------------------------------
module grq_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [grq_pkg::FIELD_W-1:0]         req_from_vertex,
   input  logic [grq_pkg::FIELD_W-1:0]         req_to_vertex,
   input  grq_pkg::cmd_type                    cmd,
   output grq_pkg::status_type                 status,
   output logic                                rsp_reachable
);
   import grq_pkg::*;

   row_type adj_mem [VERTICES];

   row_type row_valid_ff;
   row_type rdata_ff;
   logic    rvalid_ff;
   row_type visited_ff;
   row_type visited_in;
   row_type pending_ff;
   row_type pending_in;
   vtx_type from_ff;
   vtx_type to_ff;
   logic    ok_ff;
   logic    rsp_reachable_ff;

   row_type row_eff;
   row_type fresh;
   row_type pend_n;
   row_type wr_data;
   vtx_type pick;
   vtx_type rd_addr;
   logic    req_ok;

   assign req_ok = (32'(req_from_vertex) < VERTICES) && (32'(req_to_vertex) < VERTICES);

   assign row_eff = rvalid_ff ? rdata_ff : '0;
   assign fresh   = row_eff & ~visited_ff;
   assign pend_n  = pending_ff | fresh;
   assign pick    = pick_first(pend_n);
   assign wr_data = row_eff | (row_type'(1) << to_ff);
   assign rd_addr = cmd.rd_from_req ? vtx_type'(req_from_vertex) : pick;

   assign status.req_ok       = req_ok;
   assign status.more_pending = |pend_n;
   assign rsp_reachable       = rsp_reachable_ff;

   always_comb begin
      visited_in = visited_ff;
      pending_in = pending_ff;
      if (cmd.query_init) begin
         visited_in = '0;
         pending_in = '0;
      end else if (cmd.absorb) begin
         visited_in = visited_ff | fresh;
         pending_in = cmd.expand ? (pend_n & ~(row_type'(1) << pick)) : pend_n;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_write) begin
         adj_mem[from_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff  <= adj_mem[rd_addr];
         rvalid_ff <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.clear_all) begin
         row_valid_ff <= '0;
      end else if (cmd.row_write) begin
         row_valid_ff[from_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         pending_ff <= '0;
      end else begin
         visited_ff <= visited_in;
         pending_ff <= pending_in;
      end
      if (cmd.load_item) begin
         from_ff <= vtx_type'(req_from_vertex);
         to_ff   <= vtx_type'(req_to_vertex);
         ok_ff   <= req_ok;
      end
      if (cmd.load_result) begin
         rsp_reachable_ff <= ok_ff & visited_ff[to_ff];
      end
   end

endmodule
